>>> hdl/cdq_pkg.sv
// Package with the word types, operation and status codes, and defaults for the deque.
package cdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_WIDTH    = 32;

   typedef enum logic [1:0] {
      KIND_PUSH_BACK  = 2'd0,
      KIND_PUSH_FRONT = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      kind_type                       kind;
      logic signed [WORD_WIDTH-1:0]   value;
   } req_word_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0]   data;
      status_type                     status;
   } rsp_word_type;

endpackage

>>> hdl/circular_deque_unit.sv
// Top level of the circular double-ended queue of 32-bit words.
//
// A fixed-capacity deque held in one synchronous RAM of DEPTH entries, with head and tail
// indices and an entry count in registers. Each request word asks for a push at the back, a
// push at the front, a pop at the front or a pop at the back, and yields exactly one response
// word with the popped data (zero for pushes and refused pops) and a status of ok, full or
// empty. A refused operation changes nothing. The block takes one request per cycle; its
// response appears in the output register in the cycle after acceptance, through the RAM's
// registered read port. A new request is taken while the response register is empty or its
// word is being taken in the same cycle. No clearing pass is needed after reset.
module circular_deque_unit
   import cdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_INDEX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          pop_ok_ff, pop_ok_in;
   status_type    status_ff, status_in;

   logic          accept;
   logic          full;
   logic          empty;
   logic [AW-1:0] head_next, head_prev, tail_next, tail_prev;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [WORD_WIDTH-1:0] rd_data;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == FULL_COUNT);
   assign empty     = (count_ff == '0);

   assign head_next = (head_ff == LAST_INDEX) ? '0 : head_ff + AW'(1);
   assign head_prev = (head_ff == '0) ? LAST_INDEX : head_ff - AW'(1);
   assign tail_next = (tail_ff == LAST_INDEX) ? '0 : tail_ff + AW'(1);
   assign tail_prev = (tail_ff == '0) ? LAST_INDEX : tail_ff - AW'(1);

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop_ok_in    = pop_ok_ff;
      status_in    = status_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         pop_ok_in    = 1'b0;
         status_in    = STATUS_OK;
         unique case (req_word.kind)
            KIND_PUSH_BACK: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_ff;
                  tail_in  = tail_next;
                  count_in = count_ff + CW'(1);
               end
            end
            KIND_PUSH_FRONT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = head_prev;
                  head_in  = head_prev;
                  count_in = count_ff + CW'(1);
               end
            end
            KIND_POP_FRONT: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = head_ff;
                  pop_ok_in = 1'b1;
                  head_in   = head_next;
                  count_in  = count_ff - CW'(1);
               end
            end
            KIND_POP_BACK: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = tail_prev;
                  pop_ok_in = 1'b1;
                  tail_in   = tail_prev;
                  count_in  = count_ff - CW'(1);
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pop_ok_ff    <= 1'b0;
         status_ff    <= STATUS_OK;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pop_ok_ff    <= pop_ok_in;
         status_ff    <= status_in;
      end
   end

   cdq_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_word.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word.data   = pop_ok_ff ? rd_data : '0;
   assign rsp_word.status = status_ff;

endmodule

>>> hdl/cdq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
